[design/lfhs_pkg.sv]
`default_nettype none

package lfhs_pkg;

  localparam int CHANNELS    = 8;
  localparam int SAMPLE_BITS = 12;
  localparam int CH_IW       = $clog2(CHANNELS);
  localparam int WSUM_W      = 20;
  localparam int NORM_W      = 16;

  // Serial divider geometry: the gyro product needs 50 bits, the divisor 28.
  localparam int DIV_NW = 50;
  localparam int DIV_DW = 28;

  localparam logic [1:0] ACT_GYRO = 2'd0;
  localparam logic [1:0] ACT_STEP = 2'd1;
  localparam logic [1:0] ACT_ZERO = 2'd2;

  localparam logic [1:0] MODE_TRACK = 2'd1;
  localparam logic [1:0] MODE_HOLD  = 2'd2;

  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_OFFSET = 3'd1;
  localparam logic [2:0] REG_BASE   = 3'd2;
  localparam logic [2:0] REG_GAIN   = 3'd3;
  localparam logic [2:0] REG_THR    = 3'd4;
  localparam logic [2:0] REG_TARGET = 3'd5;
  localparam logic [2:0] REG_HSPEED = 3'd6;
  localparam logic [2:0] REG_LIMIT  = 3'd7;

  localparam logic [15:0] RATE_SCALE_Q20 = 16'd16011;
  localparam logic [27:0] US_TO_Q16_DIV  = 28'd256000000;

  function automatic logic signed [4:0] ch_weight(input logic [CH_IW-1:0] idx);
    logic signed [5:0] w;
    w = 6'(CHANNELS - 1) - 6'({idx, 1'b0});
    return w[4:0];
  endfunction

  function automatic logic signed [12:0] sat13(input logic signed [23:0] v);
    logic signed [12:0] r;
    if (v > 24'sd4095) r = 13'sd4095;
    else if (v < -24'sd4096) r = -13'sd4096;
    else r = v[12:0];
    return r;
  endfunction

  function automatic logic signed [8:0] sat9(input logic signed [23:0] v);
    logic signed [8:0] r;
    if (v > 24'sd255) r = 9'sd255;
    else if (v < -24'sd256) r = -9'sd256;
    else r = v[8:0];
    return r;
  endfunction

endpackage

`default_nettype wire

[design/lfhs_div.sv]
`default_nettype none

module lfhs_div #(
  parameter int NW = lfhs_pkg::DIV_NW,
  parameter int DW = lfhs_pkg::DIV_DW
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic               done_o,
  output logic [NW-1:0]      quot_o
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] num_q;
  logic [DW-1:0] den_q;
  logic [DW-1:0] rem_q, rem_d;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [DW:0]   sh;
  logic          ge;

  // Restoring division, one quotient bit per cycle; quotient bits shift in
  // where the numerator bits shift out.
  always_comb begin
    sh    = {rem_q, num_q[NW-1]};
    ge    = sh >= {1'b0, den_q};
    rem_d = ge ? DW'(sh - {1'b0, den_q}) : sh[DW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CW'(NW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NW-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

`default_nettype wire

[design/line_follow_heading_steering_top.sv]
`default_nettype none

// Steering block for a line follower. An item is a gyro sample, a heading
// zero or a control step; only a control step yields a result item. The
// block works on one item at a time, and in_ready_o is high only between
// items. A gyro sample passes through the rate product, a shift-add
// multiply by the elapsed time and then a serial divide, or ends after the
// rate product inside the deadband. A control step in tracking mode walks
// the eight channels one per cycle; with the line seen the same serial
// divider follows, with the line lost a recovery state follows, and then a
// further state when a turn is computed. Heading hold computes the error
// and then the drives; stopped mode goes straight to the result, and a
// heading zero or an unused action code never leaves idle. A
// finished result waits in an output register, so the next item is taken
// while it is still unclaimed; a step whose result finds that register
// still full waits in its last state until the register is claimed.
module line_follow_heading_steering_top (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [2:0]                       cfg_idx_i,
  input  wire logic [19:0]                      cfg_data_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [1:0]                       action_i,
  input  wire logic signed [15:0]               rate_raw_i,
  input  wire logic [15:0]                      elapsed_us_i,
  input  wire logic [lfhs_pkg::SAMPLE_BITS-1:0] refl_0_i,
  input  wire logic [lfhs_pkg::SAMPLE_BITS-1:0] refl_1_i,
  input  wire logic [lfhs_pkg::SAMPLE_BITS-1:0] refl_2_i,
  input  wire logic [lfhs_pkg::SAMPLE_BITS-1:0] refl_3_i,
  input  wire logic [lfhs_pkg::SAMPLE_BITS-1:0] refl_4_i,
  input  wire logic [lfhs_pkg::SAMPLE_BITS-1:0] refl_5_i,
  input  wire logic [lfhs_pkg::SAMPLE_BITS-1:0] refl_6_i,
  input  wire logic [lfhs_pkg::SAMPLE_BITS-1:0] refl_7_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic signed [12:0]                    left_drive_o,
  output logic signed [12:0]                    right_drive_o,
  output logic                                  stopped_o,
  output logic                                  line_lost_o,
  output logic signed [8:0]                     correction_o
);

  localparam int SB = lfhs_pkg::SAMPLE_BITS;
  localparam int CH = lfhs_pkg::CHANNELS;
  localparam int IW = lfhs_pkg::CH_IW;
  localparam int WW = lfhs_pkg::WSUM_W;
  localparam int NRW = lfhs_pkg::NORM_W;
  localparam int NW = lfhs_pkg::DIV_NW;
  localparam int DW = lfhs_pkg::DIV_DW;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_POS  = 2'd1;
  localparam logic [1:0] DIR_NEG  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_G_RATE, S_G_MUL, S_G_DIV, S_T_ACC, S_T_EVAL, S_T_DIV,
    S_R_DIFF, S_R_OUT, S_H_ERR, S_H_OUT, S_DONE
  } state_e;

  state_e state_q;

  // Configuration.
  logic [1:0]         mode_q;
  logic signed [19:0] offset_q;
  logic [9:0]         base_q, hspeed_q, limit_q;
  logic [7:0]         gain_q;
  logic [11:0]        thr_q;
  logic signed [13:0] target_q;

  // Persistent state.
  logic [31:0]   heading_q, hal_q;
  logic          lost_q;
  logic [1:0]    dir_q;
  logic [CH-1:0] last_mask_q;

  // Work registers.
  logic signed [15:0]   rraw_q;
  logic [15:0]          el_q;
  logic [CH*SB-1:0]     refl_sr_q;
  logic [IW-1:0]        ch_q;
  logic [4:0]           cnt_q;
  logic                 neg_q;
  logic [NW-1:0]        mcand_q, acc_q;
  logic signed [WW-1:0] wsum_q;
  logic [NRW-1:0]       norm_q;
  logic [CH-1:0]        mask_q;
  logic signed [33:0]   e_q;
  logic [1:0]           rdir_q;

  // Result staging and output register.
  logic signed [12:0] res_l_q, res_r_q;
  logic               res_stop_q, res_lost_q;
  logic signed [8:0]  res_c_q;
  logic               out_valid_q;
  logic signed [12:0] out_l_q, out_r_q;
  logic               out_stop_q, out_lost_q;
  logic signed [8:0]  out_c_q;

  // Divider.
  logic          div_start;
  logic [NW-1:0] div_num;
  logic [DW-1:0] div_den;
  logic          div_done;
  logic [NW-1:0] div_quot;

  lfhs_div #(.NW(NW), .DW(DW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Combinational terms.
  logic signed [20:0] diff_c;
  logic signed [35:0] rate_c;
  logic [33:0]        rmag_c;
  logic [SB-1:0]      v_c;
  logic               dark_c;
  logic [11:0]        s_c;
  logic signed [WW-1:0] term_c;
  logic signed [28:0] num_c;
  logic [27:0]        nmag_c;
  logic signed [13:0] tc_c;
  logic signed [23:0] tl_c, tr_c;
  logic [31:0]        hal_eff, chg_c;
  logic [1:0]         dir_eff;
  logic signed [33:0] re_c;
  logic signed [35:0] p4_c, pt_c;
  logic signed [19:0] pq_c, pp_c, pc_c;
  logic signed [23:0] rl_c, rr_c;
  logic signed [33:0] herr_c;
  logic signed [36:0] h5_c, ht_c;
  logic signed [20:0] hq_c, hc_c;
  logic signed [23:0] hl_c, hr_c, hlim_c;
  logic signed [31:0] hq_ext;

  always_comb begin
    diff_c = $signed({rraw_q[15], rraw_q, 4'b0}) - 21'(offset_q);
    rate_c = 36'(diff_c) * $signed({20'b0, lfhs_pkg::RATE_SCALE_Q20});
    rmag_c = rate_c[35] ? 34'(-rate_c) : rate_c[33:0];

    v_c    = refl_sr_q[SB-1:0];
    dark_c = 16'(v_c) < 16'(thr_q);
    s_c    = 12'(16'(thr_q) - 16'(v_c));
    term_c = WW'(lfhs_pkg::ch_weight(ch_q)) * $signed(WW'({1'b0, s_c}));

    num_c  = 29'(wsum_q) * $signed(29'({1'b0, gain_q}));
    nmag_c = num_c[28] ? 28'(-num_c) : num_c[27:0];

    tc_c = neg_q ? -$signed({2'b0, div_quot[11:0]}) : $signed({2'b0, div_quot[11:0]});
    tl_c = $signed({14'b0, base_q}) + 24'(tc_c);
    tr_c = $signed({14'b0, base_q}) - 24'(tc_c);

    // Recovery: the first lost step snapshots the heading and the side.
    hal_eff = lost_q ? hal_q : heading_q;
    if (lost_q) dir_eff = dir_q;
    else if (last_mask_q[CH-1 -: 2] != 2'b00) dir_eff = DIR_POS;
    else if (last_mask_q[1:0] != 2'b00) dir_eff = DIR_NEG;
    else dir_eff = DIR_NONE;
    chg_c = heading_q - hal_eff;
    re_c  = ((dir_eff == DIR_POS) ? 34'sd1966080 : -34'sd1966080) - 34'($signed(chg_c));

    p4_c = 36'(e_q) <<< 2;
    pt_c = p4_c + (p4_c[35] ? 36'sd65535 : 36'sd0);
    pq_c = pt_c[35:16];
    if (pq_c > 20'sd250) pp_c = 20'sd250;
    else if (pq_c < -20'sd250) pp_c = -20'sd250;
    else if (pq_c > 20'sd0 && pq_c < 20'sd80) pp_c = 20'sd80;
    else if (pq_c < 20'sd0 && pq_c > -20'sd80) pp_c = -20'sd80;
    else pp_c = pq_c;
    pc_c = (rdir_q == DIR_POS) ? -pp_c : pp_c;
    rl_c = $signed({14'b0, base_q}) + 24'(pc_c);
    rr_c = $signed({14'b0, base_q}) - 24'(pc_c);
    if (rl_c < 24'sd0) rl_c = 24'sd0;
    if (rr_c < 24'sd0) rr_c = 24'sd0;

    herr_c = (34'(target_q) <<< 12) - 34'($signed(heading_q));
    h5_c   = (37'(e_q) <<< 2) + 37'(e_q);
    ht_c   = h5_c + (h5_c[36] ? 37'sd65535 : 37'sd0);
    hq_c   = ht_c[36:16];
    if (hq_c > 21'sd200) hc_c = 21'sd200;
    else if (hq_c < -21'sd200) hc_c = -21'sd200;
    else hc_c = hq_c;
    hlim_c = $signed({14'b0, limit_q});
    hl_c   = $signed({14'b0, hspeed_q}) + 24'(hc_c);
    hr_c   = $signed({14'b0, hspeed_q}) - 24'(hc_c);
    if (hl_c < 24'sd0) hl_c = 24'sd0;
    else if (hl_c > hlim_c) hl_c = hlim_c;
    if (hr_c < 24'sd0) hr_c = 24'sd0;
    else if (hr_c > hlim_c) hr_c = hlim_c;

    // The heading step magnitude reaches just over 2^22, so it needs 23 bits.
    hq_ext = $signed({9'b0, div_quot[22:0]});

    div_start = 1'b0;
    div_num   = acc_q;
    div_den   = lfhs_pkg::US_TO_Q16_DIV;
    if (state_q == S_G_MUL && cnt_q == 5'd1) begin
      div_start = 1'b1;
      div_num   = el_q[0] ? acc_q + mcand_q : acc_q;
    end else if (state_q == S_T_EVAL && mask_q != '0) begin
      div_start = 1'b1;
      div_num   = NW'(nmag_c);
      div_den   = DW'(norm_q);
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= 2'd0;
      offset_q    <= '0;
      base_q      <= 10'd200;
      gain_q      <= 8'd100;
      thr_q       <= 12'd2000;
      target_q    <= '0;
      hspeed_q    <= 10'd200;
      limit_q     <= 10'd1000;
      heading_q   <= '0;
      hal_q       <= '0;
      lost_q      <= 1'b0;
      dir_q       <= DIR_NONE;
      last_mask_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          lfhs_pkg::REG_MODE:   mode_q   <= cfg_data_i[1:0];
          lfhs_pkg::REG_OFFSET: offset_q <= $signed(cfg_data_i);
          lfhs_pkg::REG_BASE:   base_q   <= cfg_data_i[9:0];
          lfhs_pkg::REG_GAIN:   gain_q   <= cfg_data_i[7:0];
          lfhs_pkg::REG_THR:    thr_q    <= cfg_data_i[11:0];
          lfhs_pkg::REG_TARGET: target_q <= $signed(cfg_data_i[13:0]);
          lfhs_pkg::REG_HSPEED: hspeed_q <= cfg_data_i[9:0];
          lfhs_pkg::REG_LIMIT:  limit_q  <= cfg_data_i[9:0];
          default: ;
        endcase
      end

      // In S_DONE the output register is reloaded below instead.
      if (out_valid_q && out_ready_i && state_q != S_DONE) out_valid_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            rraw_q    <= rate_raw_i;
            el_q      <= elapsed_us_i;
            refl_sr_q <= {refl_7_i, refl_6_i, refl_5_i, refl_4_i,
                          refl_3_i, refl_2_i, refl_1_i, refl_0_i};
            ch_q      <= '0;
            wsum_q    <= '0;
            norm_q    <= '0;
            mask_q    <= '0;
            unique case (action_i)
              lfhs_pkg::ACT_GYRO: state_q <= S_G_RATE;
              lfhs_pkg::ACT_ZERO: heading_q <= '0;
              lfhs_pkg::ACT_STEP: begin
                if (mode_q == lfhs_pkg::MODE_TRACK) begin
                  state_q <= S_T_ACC;
                end else if (mode_q == lfhs_pkg::MODE_HOLD) begin
                  state_q <= S_H_ERR;
                end else begin
                  lost_q     <= 1'b0;
                  res_l_q    <= '0;
                  res_r_q    <= '0;
                  res_stop_q <= 1'b1;
                  res_lost_q <= 1'b0;
                  res_c_q    <= '0;
                  state_q    <= S_DONE;
                end
              end
              default: ;
            endcase
          end
        end
        S_G_RATE: begin
          neg_q   <= rate_c[35];
          mcand_q <= NW'(rmag_c);
          acc_q   <= '0;
          cnt_q   <= 5'd16;
          // Rates inside the one degree per second deadband do not integrate.
          state_q <= (rmag_c > 34'h1000000) ? S_G_MUL : S_IDLE;
        end
        S_G_MUL: begin
          if (el_q[0]) acc_q <= acc_q + mcand_q;
          mcand_q <= mcand_q << 1;
          el_q    <= el_q >> 1;
          cnt_q   <= cnt_q - 5'd1;
          if (cnt_q == 5'd1) state_q <= S_G_DIV;
        end
        S_G_DIV: begin
          if (div_done) begin
            heading_q <= neg_q ? heading_q - 32'(hq_ext) : heading_q + 32'(hq_ext);
            state_q   <= S_IDLE;
          end
        end
        S_T_ACC: begin
          if (dark_c) begin
            wsum_q <= wsum_q + term_c;
            norm_q <= norm_q + NRW'(s_c);
          end
          mask_q[ch_q] <= dark_c;
          refl_sr_q    <= refl_sr_q >> SB;
          ch_q         <= ch_q + IW'(1);
          if (ch_q == IW'(CH - 1)) state_q <= S_T_EVAL;
        end
        S_T_EVAL: begin
          neg_q   <= num_c[28];
          state_q <= (mask_q != '0) ? S_T_DIV : S_R_DIFF;
        end
        S_T_DIV: begin
          if (div_done) begin
            lost_q      <= 1'b0;
            last_mask_q <= mask_q;
            res_l_q     <= lfhs_pkg::sat13(tl_c);
            res_r_q     <= lfhs_pkg::sat13(tr_c);
            res_stop_q  <= 1'b0;
            res_lost_q  <= 1'b0;
            res_c_q     <= lfhs_pkg::sat9(24'(tc_c));
            state_q     <= S_DONE;
          end
        end
        S_R_DIFF: begin
          lost_q <= 1'b1;
          hal_q  <= hal_eff;
          dir_q  <= dir_eff;
          rdir_q <= dir_eff;
          e_q    <= re_c;
          res_stop_q <= 1'b0;
          res_lost_q <= 1'b1;
          if (dir_eff != DIR_POS && dir_eff != DIR_NEG) begin
            res_l_q <= lfhs_pkg::sat13($signed({14'b0, base_q}));
            res_r_q <= lfhs_pkg::sat13($signed({14'b0, base_q}));
            res_c_q <= '0;
            state_q <= S_DONE;
          end else begin
            state_q <= S_R_OUT;
          end
        end
        S_R_OUT: begin
          res_l_q <= lfhs_pkg::sat13(rl_c);
          res_r_q <= lfhs_pkg::sat13(rr_c);
          res_c_q <= lfhs_pkg::sat9(24'(pc_c));
          state_q <= S_DONE;
        end
        S_H_ERR: begin
          e_q     <= herr_c;
          state_q <= S_H_OUT;
        end
        S_H_OUT: begin
          res_l_q    <= lfhs_pkg::sat13(hl_c);
          res_r_q    <= lfhs_pkg::sat13(hr_c);
          res_stop_q <= 1'b0;
          res_lost_q <= 1'b0;
          res_c_q    <= lfhs_pkg::sat9(24'(hc_c));
          state_q    <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_l_q     <= res_l_q;
            out_r_q     <= res_r_q;
            out_stop_q  <= res_stop_q;
            out_lost_q  <= res_lost_q;
            out_c_q     <= res_c_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign left_drive_o  = out_l_q;
  assign right_drive_o = out_r_q;
  assign stopped_o     = out_stop_q;
  assign line_lost_o   = out_lost_q;
  assign correction_o  = out_c_q;

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_G_DIV || state_q == S_T_DIV))
    else $error("divider finished outside a divide state");

  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result item appeared without a finished step");

  a_stopped_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stop_q) |->
      (out_l_q == '0 && out_r_q == '0 && out_c_q == '0 && !out_lost_q))
    else $error("stopped result item carries drive");

  a_lost_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_R_OUT) |-> lost_q)
    else $error("recovery step without the line lost flag");

endmodule

`default_nettype wire
